@@ src/nqpt_pkg.sv @@
// Shared constants for the NVMe queue pair tracker.
// Holds register indexes, result codes and doorbell layout; no dependencies.
package nqpt_pkg;

	// number of tracked queues (admin plus I/O); queue_id is one bit wide
	localparam int NUM_QUEUES = 2;
	localparam int QID_W      = 1;

	// default for the MAX_DEPTH parameter of the top level
	localparam int MAX_DEPTH_DEF = 64;

	// configuration register indexes and widths
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_DEPTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_IO   = 1'd1;
	localparam logic [CFG_DAT_W-1:0] QUEUE_DEPTH_RST = 7'd64;
	localparam logic [CFG_DAT_W-1:0] MIN_DEPTH       = 7'd2;

	// input commands
	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_POLL   = 1'b1;

	// result codes
	localparam logic [2:0] OC_SUBMITTED = 3'd0;
	localparam logic [2:0] OC_NOT_READY = 3'd1;
	localparam logic [2:0] OC_SUCCESS   = 3'd2;
	localparam logic [2:0] OC_ERROR     = 3'd3;
	localparam logic [2:0] OC_REJECTED  = 3'd4;

	// doorbell register layout
	localparam logic [15:0] DB_BASE      = 16'h1000;
	localparam logic [15:0] DB_STRIDE    = 16'(2 * 4);
	localparam logic [15:0] DB_CQ_OFFSET = 16'd4;
	localparam logic [10:0] SC_MASK      = 11'h7FF;

endpackage

@@ src/nqpt_state_mem.sv @@
// Per-queue state memory: one entry per queue, registered read.
// Entries read as the reset value until first written. Uses nqpt_pkg.
module nqpt_state_mem #(
	parameter int              DW      = 13,
	parameter logic [DW-1:0]   RST_VAL = '0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [nqpt_pkg::QID_W-1:0]   rd_addr,
	output logic [DW-1:0]                rd_data,
	input  logic                         wr_en,
	input  logic [nqpt_pkg::QID_W-1:0]   wr_addr,
	input  logic [DW-1:0]                wr_data
);

	logic [DW-1:0]                   mem_q [nqpt_pkg::NUM_QUEUES];
	logic [nqpt_pkg::NUM_QUEUES-1:0] vld_q;
	logic [DW-1:0]                   rd_raw_q;
	logic                            rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// unwritten entry reads as reset state
	assign rd_data = rd_vld_q ? rd_raw_q : RST_VAL;

endmodule

@@ src/nvme_queue_pair_tracker_core.sv @@
// Top level of the NVMe queue pair tracker: config registers, update stage,
// output register. Uses nqpt_pkg and nqpt_state_mem.
//
// channel  | direction | tdata                                   | tuser
// ---------+-----------+-----------------------------------------+---------
// s_axis   | in        | queue_id, cqe_status_word               | cmd
// m_axis   | out       | doorbell_valid, doorbell_offset,        | outcome
//          |           | doorbell_value, slot_index, status_code |
// cfg      | in        | write enable, index, data               | -
//
// One transaction per cycle sustained while m_axis is ready. An accepted transaction
// reads the state memory as it is accepted, is updated in the update stage and is
// registered into the output when that stage advances, which a stalled output delays.
// Back-to-back transactions on the same queue forward the freshly written
// entry around the registered memory read. Reset clears all queue state at once
// through per-entry valid bits; no clearing pass. A stalled output holds one
// result while one more transaction waits in the update stage.
module nvme_queue_pair_tracker_core #(
	parameter int MAX_DEPTH = nqpt_pkg::MAX_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// lowest bit up: queue_id[0], cqe_status_word[16:1], zero pad
	input  logic [23:0]                        s_tdata,
	// cmd
	input  logic                               s_tuser,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// lowest bit up: doorbell_valid[0], doorbell_offset[16:1],
	// doorbell_value[22:17], slot_index[28:23], status_code[39:29]
	output logic [39:0]                        m_tdata,
	// outcome
	output logic [2:0]                         m_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic                               cfg_we,
	input  logic [nqpt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nqpt_pkg::CFG_DAT_W-1:0]     cfg_data
);

	// pointer width, compare width (holds depth and pointer + 1), entry width
	localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CW = (PW + 1 > nqpt_pkg::CFG_DAT_W) ? PW + 1 : nqpt_pkg::CFG_DAT_W;
	localparam int DW = 2 * PW + 1;
	// entry layout: {expected_phase, complete_head, submit_tail}
	localparam logic [DW-1:0] ENT_RST = {1'b1, {(2 * PW){1'b0}}};

	// configuration registers
	logic [nqpt_pkg::CFG_DAT_W-1:0] depth_q;
	logic                           active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= nqpt_pkg::QUEUE_DEPTH_RST;
			active_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				nqpt_pkg::REG_QUEUE_DEPTH: depth_q  <= cfg_data;
				nqpt_pkg::REG_ACTIVE_IO:   active_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp depth into [2, MAX_DEPTH]
	logic [CW-1:0] depth_eff;
	always_comb begin
		depth_eff = CW'(depth_q);
		if (depth_eff < CW'(nqpt_pkg::MIN_DEPTH)) begin
			depth_eff = CW'(nqpt_pkg::MIN_DEPTH);
		end else if (depth_eff > CW'(MAX_DEPTH)) begin
			depth_eff = CW'(MAX_DEPTH);
		end
	end

	// handshake and stage control
	logic s_accept;
	logic s1_valid_q;
	logic s1_adv;
	logic out_valid_q;

	assign s_accept = s_tvalid && s_tready;
	assign s1_adv   = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;

	// write-back path
	logic                         wr_en;
	logic [nqpt_pkg::QID_W-1:0]   wr_addr;
	logic [DW-1:0]                wr_data;
	logic [DW-1:0]                rd_data;

	// update stage payload
	logic                         cmd_s1;
	logic [nqpt_pkg::QID_W-1:0]   qid_s1;
	logic [15:0]                  word_s1;
	logic                         fwd_hit_s1;
	logic [DW-1:0]                fwd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// capture payload and note a same-edge write to the entry being read
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1      <= s_tuser;
			qid_s1      <= s_tdata[0];
			word_s1     <= s_tdata[16:1];
			fwd_hit_s1  <= wr_en && (wr_addr == s_tdata[0]);
			fwd_data_s1 <= wr_data;
		end
	end

	nqpt_state_mem #(
		.DW      (DW),
		.RST_VAL (ENT_RST)
	) u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_accept),
		.rd_addr (s_tdata[0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// current entry, forwarded when the previous transaction just wrote it
	logic [DW-1:0] ent;
	logic [PW-1:0] tail;
	logic [PW-1:0] head;
	logic          phase;
	logic [CW-1:0] tail_inc;
	logic [CW-1:0] head_inc;
	logic [PW-1:0] tail_nx;
	logic [PW-1:0] head_nx;
	logic          head_wrap;
	logic          rejected;
	logic [15:0]   sq_db;
	logic [10:0]   sc;

	assign ent   = fwd_hit_s1 ? fwd_data_s1 : rd_data;
	assign tail  = ent[PW-1:0];
	assign head  = ent[2*PW-1:PW];
	assign phase = ent[DW-1];

	assign tail_inc  = CW'(tail) + CW'(1);
	assign head_inc  = CW'(head) + CW'(1);
	assign tail_nx   = (tail_inc >= depth_eff) ? '0 : tail_inc[PW-1:0];
	assign head_wrap = (head_inc >= depth_eff);
	assign head_nx   = head_wrap ? '0 : head_inc[PW-1:0];

	assign rejected = (int'(qid_s1) >= nqpt_pkg::NUM_QUEUES)
		|| ((qid_s1 != '0) && (qid_s1 > active_q));
	assign sq_db = nqpt_pkg::DB_BASE + 16'(qid_s1) * nqpt_pkg::DB_STRIDE;
	assign sc    = word_s1[11:1] & nqpt_pkg::SC_MASK;

	// result and next entry
	logic [2:0]    res_oc;
	logic          res_dv;
	logic [15:0]   res_off;
	logic [5:0]    res_val;
	logic [5:0]    res_slot;
	logic [10:0]   res_sc;
	logic          upd;

	always_comb begin
		res_oc   = nqpt_pkg::OC_REJECTED;
		res_dv   = 1'b0;
		res_off  = '0;
		res_val  = '0;
		res_slot = '0;
		res_sc   = '0;
		upd      = 1'b0;
		wr_data  = ent;
		if (!rejected) begin
			if (cmd_s1 == nqpt_pkg::CMD_SUBMIT) begin
				// take slot at tail, advance tail
				res_oc   = nqpt_pkg::OC_SUBMITTED;
				res_dv   = 1'b1;
				res_off  = sq_db;
				res_val  = 6'(tail_nx);
				res_slot = 6'(tail);
				upd      = 1'b1;
				wr_data  = {phase, head, tail_nx};
			end else if (word_s1[0] != phase) begin
				// entry not yet posted; report head only
				res_oc   = nqpt_pkg::OC_NOT_READY;
				res_slot = 6'(head);
			end else begin
				// consume entry, flip phase on wrap
				res_oc   = (sc == '0) ? nqpt_pkg::OC_SUCCESS : nqpt_pkg::OC_ERROR;
				res_dv   = 1'b1;
				res_off  = sq_db + nqpt_pkg::DB_CQ_OFFSET;
				res_val  = 6'(head_nx);
				res_slot = 6'(head);
				res_sc   = sc;
				upd      = 1'b1;
				wr_data  = {phase ^ head_wrap, head_nx, tail};
			end
		end
	end

	assign wr_en   = s1_adv && upd;
	assign wr_addr = qid_s1;

	// output register
	logic [39:0] out_data_q;
	logic [2:0]  out_oc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= {res_sc, res_slot, res_val, res_off, res_dv};
			out_oc_q   <= res_oc;
		end
	end

	assign m_tdata  = out_data_q;
	assign m_tuser  = out_oc_q;
	assign m_tvalid = out_valid_q;

	// write-back only from an occupied update stage that hands off its result
	a_wr_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (s1_valid_q && (!out_valid_q || m_tready)))
		else $error("state write without a transaction leaving the update stage");

	// input stalls only when both the update stage and output register are full
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && out_valid_q && !m_tready))
		else $error("input stalled with room downstream");

	// rejected and not-ready results never carry a doorbell
	a_no_db_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == nqpt_pkg::OC_REJECTED || m_tuser == nqpt_pkg::OC_NOT_READY))
		|-> (m_tdata[0] == 1'b0))
		else $error("doorbell issued on rejected or not-ready result");

	// a same-queue write during acceptance always sets the forwarding flag
	a_fwd_same_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && wr_en && (wr_addr == s_tdata[0])) |=> fwd_hit_s1)
		else $error("missed forwarding of a same-queue write");

endmodule
